FILE: rtl/core/assert_macros.svh
// Assertion helpers used by the rate limiter unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is checked only while reset is released.
`define PCWRL_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked in every cycle, reset included.
`define PCWRL_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/pcwrl_pkg.sv
package pcwrl_pkg;

  localparam int unsigned NumCodesDefault = 16;
  localparam int unsigned CodeW           = 4;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned CountW          = 16;
  localparam int unsigned TotalW          = 32;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 32;

  localparam logic [CountW-1:0] EventsPerWindowReset = CountW'(10);
  localparam logic [TimeW-1:0]  WindowTicksReset     = TimeW'(1000);
  localparam logic [TotalW-1:0] TotalMax             = '1;

  typedef enum logic [1:0] {
    ModeEvent = 2'd0,
    ModeQuery = 2'd1,
    ModeClear = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEventsPerWindow = 1'b0,
    CfgWindowTicks     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CodeW-1:0] code;
    logic [TimeW-1:0] now_time;
  } req_t;

  typedef struct packed {
    logic              allowed;
    logic [TotalW-1:0] throttled_total;
    logic [TimeW-1:0]  throttle_span;
    logic              has_report;
  } rsp_t;

  // One table entry as it is kept in the entry memory.
  typedef struct packed {
    logic [CountW-1:0] window_count;
    logic [TimeW-1:0]  window_begin;
    logic [TotalW-1:0] suppressed_count;
    logic [TimeW-1:0]  first_suppressed;
    logic [TimeW-1:0]  last_suppressed;
  } entry_t;

  typedef struct packed {
    logic [CountW-1:0] events_per_window;
    logic [TimeW-1:0]  window_ticks;
  } cfg_t;

endpackage

FILE: rtl/core/pcwrl_entry_mem.sv
module pcwrl_entry_mem import pcwrl_pkg::*; #(
  parameter int unsigned Depth = NumCodesDefault,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pcwrl_update.sv
module pcwrl_update import pcwrl_pkg::*; (
  input  logic       valid_i,
  input  entry_t     entry_i,
  input  logic       event_i,
  input  logic [TimeW-1:0] now_i,
  input  cfg_t       cfg_i,
  output entry_t     entry_o,
  output rsp_t       rsp_o
);

  entry_t            base;
  entry_t            upd;
  logic [TimeW-1:0]  elapsed;
  logic              report;

  assign elapsed = now_i - entry_i.window_begin;

  always_comb begin
    base = entry_i;
    if (!valid_i) begin
      base = '0;
      base.window_begin = now_i;
    end else if (elapsed >= cfg_i.window_ticks) begin
      base.window_count = '0;
      base.window_begin = now_i;
    end

    upd = base;
    if (base.window_count >= cfg_i.events_per_window) begin
      if (base.suppressed_count != TotalMax) begin
        upd.suppressed_count = base.suppressed_count + TotalW'(1);
        // The first suppression of the entry also marks the start of the span.
        if (base.suppressed_count == '0) begin
          upd.first_suppressed = now_i;
        end
      end
      upd.last_suppressed = now_i;
    end else begin
      upd.window_count = base.window_count + CountW'(1);
    end
  end

  assign entry_o = upd;

  always_comb begin
    rsp_o = '0;
    if (event_i) begin
      report = upd.suppressed_count != '0;
      rsp_o.allowed = base.window_count < cfg_i.events_per_window;
      if (report) begin
        rsp_o.throttled_total = upd.suppressed_count;
        rsp_o.throttle_span   = upd.last_suppressed - upd.first_suppressed;
        rsp_o.has_report      = 1'b1;
      end
    end else begin
      report = valid_i && (entry_i.suppressed_count != '0);
      if (report) begin
        rsp_o.throttled_total = entry_i.suppressed_count;
        rsp_o.throttle_span   = entry_i.last_suppressed - entry_i.first_suppressed;
        rsp_o.has_report      = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/per_code_window_rate_limiter_unit.sv
// Per-code fixed-window rate limiter.
// A request is issued by raising start with a payload on req_i while busy is
// low; mode selects an event, a report query or a clear of all entries.
// The code selects one table entry whose window, count and suppression
// record live in a synchronous entry memory; the valid bits are flops.
// The accept edge reads the entry, the next cycle updates and writes it
// back, and the response appears on rsp_o with done_o high in the cycle
// after that, for exactly one cycle. The receiver cannot stall.
// A new request is taken only after the previous one has finished its
// update; busy is high in the update cycle, so reads never overlap a
// pending write. Configuration is written through cfg_we_i, cfg_idx_i
// and cfg_wdata_i; the user must do so only while the block is idle,
// which the block does not enforce. Reset invalidates every entry at
// once and restores the default limit of 10 events per 1000-tick window.
`include "assert_macros.svh"

module per_code_window_rate_limiter_unit import pcwrl_pkg::*; #(
  parameter int unsigned NUM_CODES = NumCodesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output rsp_t                rsp_o
);

  localparam int unsigned IdxW = $clog2(NUM_CODES);
  localparam int unsigned WideW = IdxW + CodeW;

  typedef enum logic {
    Idle,
    Exec
  } state_e;

  state_e               state_q;
  req_t                 req_q;
  rsp_t                 rsp_q;
  logic                 done_q;
  logic [NUM_CODES-1:0] valid_q;
  cfg_t                 cfg_q;

  logic                 accept;
  logic [WideW-1:0]     in_code_wide;
  logic [WideW-1:0]     q_code_wide;
  logic [IdxW-1:0]      in_idx;
  logic [IdxW-1:0]      q_idx;
  logic                 in_range;
  logic                 is_event;
  logic                 is_clear;
  logic                 rsp_take;
  logic                 mem_we;
  entry_t               rd_entry;
  entry_t               wr_entry;
  rsp_t                 upd_rsp;

  assign accept       = start && !busy;
  assign busy         = state_q == Exec;
  assign in_code_wide = {{IdxW{1'b0}}, req_i.code};
  assign q_code_wide  = {{IdxW{1'b0}}, req_q.code};
  assign in_idx       = in_code_wide[IdxW-1:0];
  assign q_idx        = q_code_wide[IdxW-1:0];
  assign in_range     = q_code_wide < WideW'(NUM_CODES);
  assign is_event     = req_q.mode == ModeEvent;
  assign is_clear     = req_q.mode == ModeClear;
  assign rsp_take     = in_range && (is_event || req_q.mode == ModeQuery);
  assign mem_we       = busy && is_event && in_range;

  pcwrl_entry_mem #(
    .Depth (NUM_CODES)
  ) u_entry_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (q_idx),
    .wdata_i (wr_entry),
    .re_i    (accept),
    .raddr_i (in_idx),
    .rdata_o (rd_entry)
  );

  pcwrl_update u_update (
    .valid_i (valid_q[q_idx]),
    .entry_i (rd_entry),
    .event_i (is_event),
    .now_i   (req_q.now_time),
    .cfg_i   (cfg_q),
    .entry_o (wr_entry),
    .rsp_o   (upd_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.events_per_window <= EventsPerWindowReset;
      cfg_q.window_ticks      <= WindowTicksReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgEventsPerWindow: cfg_q.events_per_window <= cfg_wdata_i[CountW-1:0];
        CfgWindowTicks:     cfg_q.window_ticks      <= cfg_wdata_i[TimeW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      req_q   <= '0;
      rsp_q   <= '0;
      done_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      done_q <= state_q == Exec;
      unique case (state_q)
        Idle: begin
          if (accept) begin
            req_q   <= req_i;
            state_q <= Exec;
          end
        end
        Exec: begin
          state_q <= Idle;
          rsp_q   <= rsp_take ? upd_rsp : '0;
          unique case (req_q.mode)
            ModeEvent: begin
              if (in_range) begin
                valid_q[q_idx] <= 1'b1;
              end
            end
            ModeClear: valid_q <= '0;
            default: ;
          endcase
        end
      endcase
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `PCWRL_ASSERT(a_accept_then_busy, clk_i, rst_ni, accept |=> busy, "request not taken up")
  `PCWRL_ASSERT(a_busy_then_done, clk_i, rst_ni, busy |=> (done_o && !busy), "no response")
  `PCWRL_ASSERT(a_clear_empties, clk_i, rst_ni, (busy && is_clear) |=> !(|valid_q), "clear failed")
  `PCWRL_ASSERT_ALWAYS(a_write_in_update, clk_i, mem_we |-> busy, "write outside update")

endmodule
